/* rtl/nno_pkg.sv */
// Shared constants and control/status types for the nearest-neighbor ordering block.
// No dependencies; every other file imports this package.
package nno_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 10;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SUM_W      = COORD_BITS + 1;
    localparam int OUT_IDX_W  = 5;
    localparam int DIST_W     = 11;

    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic walk_init;  // clear visited marks and step count
        logic scan_run;   // sweep the point store
        logic emit;       // commit the best point and load the output register
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic last_step;
        logic found;
    } t_status;

endpackage

/* rtl/nno_dp.sv */
// Datapath: point store memory, visited marks, scan pipeline and result registers.
// Depends on nno_pkg; driven by commands from nno_ctrl.
module nno_dp import nno_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    output t_status               o_status,
    output logic [OUT_IDX_W-1:0]  o_point_index,
    output logic [DIST_W-1:0]     o_leg_distance,
    output logic                  o_run_end,
    output logic                  o_overflow
);

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [COORD_BITS-1:0] r_mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] r_mem_y [MAX_POINTS];
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y;

    logic [CNT_W-1:0]      r_count, r_scan, r_step;
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y;
    logic                  r_dropped;
    logic [MAX_POINTS-1:0] r_visited;

    logic                  r_cmp_valid;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [SUM_W-1:0]      r_best_d;
    logic [IDX_W-1:0]      r_best_idx;
    logic [COORD_BITS-1:0] r_best_x, r_best_y;

    logic [OUT_IDX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0]     r_out_dist;
    logic                  r_out_end, r_out_ovf;

    logic                  room, scan_more, take;
    logic [SUM_W-1:0]      leg_dist;

    assign room      = (r_count < CNT_W'(MAX_POINTS));
    assign scan_more = i_cmd.scan_run && (r_scan < r_count);
    assign leg_dist  = SUM_W'(abs_diff(r_cur_x, r_rd_x)) + SUM_W'(abs_diff(r_cur_y, r_rd_y));
    // Later indices win ties, so an equal distance also replaces the best.
    assign take      = r_cmp_valid && !r_visited[r_cmp_idx] && (!r_found || leg_dist <= r_best_d);

    // Point store: one write port at the fill count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_mode && room) begin
            r_mem_x[r_count[IDX_W-1:0]] <= i_x;
            r_mem_y[r_count[IDX_W-1:0]] <= i_y;
        end
        r_rd_x <= r_mem_x[r_scan[IDX_W-1:0]];
        r_rd_y <= r_mem_y[r_scan[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_dropped   <= 1'b0;
            r_visited   <= '0;
            r_scan      <= '0;
            r_step      <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_cmp_valid <= scan_more;
            if (scan_more) begin
                r_scan <= r_scan + 1'b1;
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.accept) begin
                if (!i_mode) begin
                    r_cur_x   <= i_x;
                    r_cur_y   <= i_y;
                    r_count   <= '0;
                    r_dropped <= 1'b0;
                end else if (room) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.walk_init) begin
                r_visited <= '0;
                r_step    <= '0;
                r_scan    <= '0;
                r_found   <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_visited[r_best_idx] <= 1'b1;
                r_cur_x <= r_best_x;
                r_cur_y <= r_best_y;
                r_step  <= r_step + 1'b1;
                r_scan  <= '0;
                r_found <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_scan[IDX_W-1:0];
        if (take) begin
            r_best_d   <= leg_dist;
            r_best_idx <= r_cmp_idx;
            r_best_x   <= r_rd_x;
            r_best_y   <= r_rd_y;
        end
        if (i_cmd.emit) begin
            r_out_idx  <= OUT_IDX_W'(r_best_idx);
            r_out_dist <= DIST_W'(r_best_d);
            r_out_end  <= o_status.last_step;
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_done  = (r_scan == r_count) && !r_cmp_valid;
    assign o_status.last_step  = ((r_step + 1'b1) == r_count);
    assign o_status.found      = r_found;

    assign o_point_index  = r_out_idx;
    assign o_leg_distance = r_out_dist;
    assign o_run_end      = r_out_end;
    assign o_overflow     = r_out_ovf;

endmodule

/* rtl/nno_ctrl.sv */
// Controller: state machine that sequences loading, scanning and result handoff.
// Depends on nno_pkg; commands nno_dp and owns both handshakes.
module nno_ctrl import nno_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_set_end,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   emit_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign emit_fire  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    assign o_cmd.accept    = i_in_valid && o_in_ready;
    assign o_cmd.walk_init = (r_state == S_PREP);
    assign o_cmd.scan_run  = (r_state == S_SCAN);
    assign o_cmd.emit      = emit_fire;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_set_end) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = i_status.count_zero ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_fire) begin
                    n_state = i_status.last_step ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/nearest_neighbor_ordering_top.sv */
// Top level of the greedy nearest-neighbor ordering block (Manhattan distance).
// Depends on nno_pkg, nno_ctrl and nno_dp.
//
// Usage: input transactions carry mode, x, y and set_end. A mode 0 transaction
// sets the walker position and opens an empty set; a mode 1 transaction appends
// a point to the store, up to MAX_POINTS points, and later points are dropped
// and flagged through overflow. A transaction with set_end high starts the walk
// once it has been applied. The walk emits one output transaction per stored
// point, in visiting order, with the point's load index, the leg distance and
// run_end on the last one. Points stay stored after a walk.
// Loading accepts one transaction per cycle while the input is ready. For each
// result of a walk, the single read port of the point store sweeps the stored
// points once, the read and compare stages drain, and the pick is committed.
// A setup state precedes the walk. The input is not ready while a walk runs.
// Reset (synchronous, active low) empties the set, clears the overflow flag and
// puts the walker at (0, 0); store contents are not cleared. When the receiver
// stalls, the finished result sits in the output register while the next scan
// runs, and the walk holds before committing the next pick until it is taken.
module nearest_neighbor_ordering_top import nno_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic                  i_set_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_IDX_W-1:0]  o_point_index,
    output logic [DIST_W-1:0]     o_leg_distance,
    output logic                  o_run_end,
    output logic                  o_overflow
);

    t_cmd    cmd;
    t_status status;

    // The controller owns the handshakes and the sequencing of each walk.
    nno_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_set_end   (i_set_end),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the points, the walker position and the result register.
    nno_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_x            (i_x),
        .i_y            (i_y),
        .o_status       (status),
        .o_point_index  (o_point_index),
        .o_leg_distance (o_leg_distance),
        .o_run_end      (o_run_end),
        .o_overflow     (o_overflow)
    );

    // A transaction that ends a set must close the input while the walk is set up.
    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_set_end) |=> !o_in_ready)
        else $error("input stayed ready after a set_end transaction");

    // Every committed pick must come from a scan that found an unvisited point.
    a_emit_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.found)
        else $error("result committed without a candidate point");

    // Committing the last pick returns the block to accepting input.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && status.last_step) |=> (o_in_ready && o_out_valid && o_run_end))
        else $error("walk did not finish cleanly after its last result");

endmodule
